@@ rtl/flight_mode_supervisor_defines.svh @@
// Assertion macros for the flight mode supervisor checker.
// No dependencies; pulled in by the checker with an include.
`ifndef FLIGHT_MODE_SUPERVISOR_DEFINES_SVH
`define FLIGHT_MODE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define FMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flight mode supervisor: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define FMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flight mode supervisor: next-cycle check failed");

`endif

@@ rtl/fms_pkg.sv @@
// Shared types, mode and operation codes, and step helpers for the supervisor.
// No dependencies.
package fms_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int MODE_W        = 4;
    localparam int OP_W          = 2;
    localparam int CMP_W         = (COUNTER_WIDTH > CFG_DATA_W) ? COUNTER_WIDTH : CFG_DATA_W;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    localparam logic [CFG_DATA_W-1:0] WATCHDOG_LIMIT_RST = CFG_DATA_W'(100);
    localparam logic [CFG_DATA_W-1:0] ESCALATE_DWELL_RST = CFG_DATA_W'(500);

    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCALATE_DWELL = 1'b1;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_REQUEST   = 2'd2;
    localparam logic [OP_W-1:0] OP_STARTUP   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_BOOT    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_RADIO   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SENSOR  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_CONTROL = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SAFE    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ARMED   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_MANUAL  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_AUTO    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_FAULT   = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] req;
        logic              ok;
        logic              done;
    } fms_item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              trip;
        logic              accepted;
        logic              zero_motors;
        logic              zero_targets;
        logic              expired;
    } fms_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              accept;
        logic              zero_motors;
        logic              zero_targets;
        logic              clear_safe;
    } fms_ask_t;

    function automatic logic [COUNTER_WIDTH-1:0] count_up(input logic [COUNTER_WIDTH-1:0] c);
        count_up = (c == CNT_MAX) ? CNT_MAX : c + COUNTER_WIDTH'(1);
    endfunction

    // Outcome of asking for a mode change from the current mode.
    function automatic fms_ask_t ask_mode(input logic [MODE_W-1:0] want,
                                          input logic [MODE_W-1:0] cur);
        fms_ask_t r;
        r      = '0;
        r.mode = cur;
        if (want == cur) begin
            r.accept = 1'b1;
        end else if (cur != MODE_FAULT) begin
            if (want == MODE_SAFE) begin
                r.accept      = 1'b1;
                r.mode        = MODE_SAFE;
                r.zero_motors = 1'b1;
                r.clear_safe  = 1'b1;
            end else if (want == MODE_ARMED) begin
                r.accept = 1'b1;
                r.mode   = MODE_ARMED;
            end else if (want == MODE_MANUAL) begin
                r.accept       = 1'b1;
                r.mode         = MODE_MANUAL;
                r.zero_targets = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/fms_core.sv @@
// Supervisor state, configuration registers and the combinational step logic.
// Depends on fms_pkg.
module fms_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step_en,
    input  fms_pkg::fms_item_t               item,
    input  logic                             cfg_we,
    input  logic [fms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fms_pkg::fms_result_t             result
);
    import fms_pkg::*;

    logic [CFG_DATA_W-1:0]    wd_limit_reg;
    logic [CFG_DATA_W-1:0]    dwell_reg;
    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [MODE_W-1:0]        last_req_reg, last_req_next;
    logic                     trip_reg, trip_next;
    logic [COUNTER_WIDTH-1:0] feed_reg, feed_next;
    logic [COUNTER_WIDTH-1:0] safe_reg, safe_next;

    logic [COUNTER_WIDTH-1:0] feed_inc;
    logic                     do_ask;
    logic [MODE_W-1:0]        want;
    logic                     expired;
    logic                     fed;
    logic                     dwell_passed;
    logic                     held;
    fms_ask_t                 ask;

    assign feed_inc     = count_up(feed_reg);
    assign fed          = (CMP_W'(feed_inc) < CMP_W'(wd_limit_reg)) && (feed_inc != CNT_MAX);
    assign dwell_passed = (CMP_W'(safe_reg) >= CMP_W'(dwell_reg)) || (safe_reg == CNT_MAX);
    assign held         = (item.req > MODE_SAFE) && (mode_reg <= MODE_SAFE) && !dwell_passed;
    assign ask          = ask_mode(want, mode_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        last_req_next = last_req_reg;
        trip_next     = trip_reg;
        feed_next     = feed_reg;
        safe_next     = safe_reg;
        do_ask        = 1'b0;
        want          = item.req;
        expired       = 1'b0;
        case (item.op)
            OP_TICK:
            begin
                feed_next = feed_inc;
                safe_next = count_up(safe_reg);
                if (mode_reg >= MODE_ARMED && mode_reg != MODE_FAULT && !fed)
                begin
                    trip_next = 1'b1;
                    expired   = 1'b1;
                    do_ask    = 1'b1;
                    want      = MODE_SAFE;
                end
            end
            OP_HEARTBEAT:
            begin
                feed_next = '0;
                // act only on a changed request that is not held by the dwell
                if (item.req != last_req_reg && !held)
                begin
                    last_req_next = item.req;
                    if (item.req <= MODE_SAFE)
                    begin
                        trip_next = 1'b0;
                    end
                    do_ask = 1'b1;
                end
            end
            OP_REQUEST:
            begin
                do_ask = 1'b1;
            end
            default:
            begin
                case (mode_reg)
                    MODE_BOOT:
                    begin
                        mode_next = item.ok ? MODE_RADIO : MODE_FAULT;
                    end
                    MODE_RADIO, MODE_SENSOR:
                    begin
                        if (!item.ok)
                        begin
                            mode_next = MODE_FAULT;
                        end else if (item.done)
                        begin
                            mode_next = mode_reg + MODE_W'(1);
                        end
                    end
                    MODE_CONTROL:
                    begin
                        mode_next = MODE_SAFE;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        endcase
        if (do_ask)
        begin
            mode_next = ask.mode;
            if (ask.clear_safe)
            begin
                safe_next = '0;
            end
        end
    end

    assign result.mode         = mode_next;
    assign result.trip         = trip_next;
    assign result.accepted     = do_ask & ask.accept;
    assign result.zero_motors  = do_ask & ask.zero_motors;
    assign result.zero_targets = do_ask & ask.zero_targets;
    assign result.expired      = expired;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_limit_reg <= WATCHDOG_LIMIT_RST;
            dwell_reg    <= ESCALATE_DWELL_RST;
        end else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WATCHDOG_LIMIT: wd_limit_reg <= cfg_data;
                CFG_ESCALATE_DWELL: dwell_reg    <= cfg_data;
                default:            wd_limit_reg <= wd_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_BOOT;
            last_req_reg <= MODE_BOOT;
            trip_reg     <= 1'b0;
            feed_reg     <= '0;
            safe_reg     <= '0;
        end else if (step_en)
        begin
            mode_reg     <= mode_next;
            last_req_reg <= last_req_next;
            trip_reg     <= trip_next;
            feed_reg     <= feed_next;
            safe_reg     <= safe_next;
        end
    end

endmodule

@@ rtl/flight_mode_supervisor.sv @@
// The input register holds an accepted item and feeds the step logic, which
// writes the result register. Throughput: one item per cycle while out_ready
// is high; a result held by !out_ready stalls the step and a full input register.
// Reset: rst_n clears mode, trip flag, counters and both valid flags at once
// and loads the watchdog limit (100) and escalation dwell (500).
// Depends on fms_pkg and fms_core.
module flight_mode_supervisor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fms_pkg::OP_W-1:0]        operation,
    input  logic [fms_pkg::MODE_W-1:0]      requested_mode,
    input  logic                            setup_ok,
    input  logic                            setup_done,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fms_pkg::MODE_W-1:0]      mode,
    output logic                            trip_latched,
    output logic                            request_accepted,
    output logic                            zero_motors,
    output logic                            zero_targets,
    output logic                            watchdog_expired
);
    import fms_pkg::*;

    logic        in_valid_reg;
    fms_item_t   in_item_reg;
    logic        out_valid_reg;
    fms_result_t result_reg;
    fms_result_t step_result;
    logic        step_en;

    // step the held item when the result register is free or being drained
    assign step_en  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_en;

    fms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.op   <= operation;
            in_item_reg.req  <= requested_mode;
            in_item_reg.ok   <= setup_ok;
            in_item_reg.done <= setup_done;
        end
        if (step_en)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mode             = result_reg.mode;
    assign trip_latched     = result_reg.trip;
    assign request_accepted = result_reg.accepted;
    assign zero_motors      = result_reg.zero_motors;
    assign zero_targets     = result_reg.zero_targets;
    assign watchdog_expired = result_reg.expired;

endmodule

@@ rtl/fms_checker.sv @@
// Port-level checker for the flight mode supervisor, bound to the top level.
// Depends on fms_pkg and flight_mode_supervisor_defines.svh.
`include "flight_mode_supervisor_defines.svh"

module fms_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [fms_pkg::MODE_W-1:0]      mode,
    input logic                            trip_latched,
    input logic                            request_accepted,
    input logic                            zero_motors,
    input logic                            zero_targets,
    input logic                            watchdog_expired
);
    import fms_pkg::*;

    logic fault_seen_reg;

    // remember that a delivered item reported FAULT
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_seen_reg <= 1'b0;
        end else if (out_valid && out_ready && mode == MODE_FAULT)
        begin
            fault_seen_reg <= 1'b1;
        end
    end

    `FMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(mode) && $stable(trip_latched))
    `FMS_ASSERT_NOW(a_fault_terminal, out_valid && fault_seen_reg, mode == MODE_FAULT)
    `FMS_ASSERT_NOW(a_expiry_forces_safe, out_valid && watchdog_expired,
        mode == MODE_SAFE && trip_latched && request_accepted && zero_motors)
    `FMS_ASSERT_NOW(a_manual_entry, out_valid && zero_targets,
        mode == MODE_MANUAL && request_accepted && !zero_motors && !watchdog_expired)

endmodule

bind flight_mode_supervisor fms_checker u_fms_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mode             (mode),
    .trip_latched     (trip_latched),
    .request_accepted (request_accepted),
    .zero_motors      (zero_motors),
    .zero_targets     (zero_targets),
    .watchdog_expired (watchdog_expired)
);
